/* src/sequential_list_engine_macros.svh */
// Assertion macros used by the list engine RTL.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Checked on every clock edge outside of reset.
`define SLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SLE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/sle_pkg.sv */
`timescale 1ns / 1ps

package sle_pkg;

	localparam int CAP    = 32;
	localparam int IDX_W  = $clog2(CAP);
	localparam int POS_W  = 6;
	localparam int OP_W   = 3;
	localparam int DATA_W = 32;
	localparam int FPOS_W = 5;
	localparam int STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_ERASE  = 3'd2,
		OP_SEARCH = 3'd3,
		OP_VISIT  = 3'd4,
		OP_CLEAR  = 3'd5
	} op_e;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} stat_e;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_e;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_e;

	// Broadcast to every cell of the row.
	typedef struct packed {
		cell_op_e                 kind;
		logic [POS_W-1:0]         pos;
		logic [POS_W-1:0]         tail;
		logic                     keep;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

/* src/sle_req_if.sv */
`timescale 1ns / 1ps

interface sle_req_if import sle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);
endinterface

/* src/sle_rsp_if.sv */
`timescale 1ns / 1ps

interface sle_rsp_if import sle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic                     found;
	logic [FPOS_W-1:0]        found_position;
	logic [POS_W-1:0]         entry_count;
	logic [STAT_W-1:0]        status;

	modport source (output valid, output read_value, output found, output found_position,
		output entry_count, output status, input ready);
	modport sink (input valid, input read_value, input found, input found_position,
		input entry_count, input status, output ready);
endinterface

/* src/sequential_list_engine.sv */
`timescale 1ns / 1ps
// A search of a non-empty list and an erase in range rotate the row of cells once, one
// entry through the head per cycle; no transaction is taken until the scan ends, and the
// result is then registered. Every other transaction finishes at once: its result is
// registered and shows in the cycle after the input transaction, and the next can follow
// at once if the result slot is free or being drained, the only time a transaction is taken.
// Reset clears the entry count and the handshake state; entry contents are left as they are.
`include "sequential_list_engine_macros.svh"

module sequential_list_engine import sle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);

	state_e                   state_q, state_d;
	logic [POS_W-1:0]         count_q, count_d;
	logic                     scan_erase_q;
	logic signed [DATA_W-1:0] key_q;
	logic [POS_W-1:0]         step_q, steps_q, n_q;
	logic                     found_q;
	logic [FPOS_W-1:0]        fpos_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_rd_q;
	logic                     out_found_q;
	logic [FPOS_W-1:0]        out_fpos_q;
	logic [POS_W-1:0]         out_count_q;
	stat_e                    out_stat_q;

	logic                     accept;
	logic                     scan_start;
	logic                     scan_last;
	logic                     load_out;
	logic                     head_hit;
	logic                     keep;
	cell_cmd_t                cmd;
	logic signed [DATA_W-1:0] rd_data, head_data;
	logic signed [DATA_W-1:0] res_rd;
	logic                     res_found;
	logic [FPOS_W-1:0]        res_fpos;
	stat_e                    res_stat;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign head_hit  = (head_data == key_q);
	assign keep      = scan_erase_q ? !head_hit : 1'b1;
	assign scan_last = (step_q == steps_q - POS_W'(1));

	sle_row u_row (
		.clk       (clk),
		.cmd       (cmd),
		.rd_idx    (req.position[IDX_W-1:0]),
		.rd_data   (rd_data),
		.head_data (head_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && scan_start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '{kind: CELL_HOLD, pos: req.position, tail: n_q - POS_W'(1),
			keep: keep, value: req.value};
		count_d    = count_q;
		scan_start = 1'b0;
		load_out   = 1'b0;
		res_rd     = '0;
		res_found  = 1'b0;
		res_fpos   = '0;
		res_stat   = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					case (op_e'(req.op))
						OP_INSERT: begin
							if (count_q >= POS_W'(CAP)) begin
								res_stat = ST_FULL;
							end else if (req.position > count_q) begin
								res_stat = ST_RANGE;
							end else begin
								cmd.kind = CELL_INSERT;
								count_d  = count_q + POS_W'(1);
							end
						end
						OP_REMOVE: begin
							if (req.position >= count_q) begin
								res_stat = ST_RANGE;
							end else begin
								cmd.kind = CELL_REMOVE;
								count_d  = count_q - POS_W'(1);
							end
						end
						OP_ERASE: begin
							if (req.position >= count_q) begin
								res_stat = ST_RANGE;
							end else begin
								scan_start = 1'b1;
								load_out   = 1'b0;
							end
						end
						OP_SEARCH: begin
							if (count_q != '0) begin
								scan_start = 1'b1;
								load_out   = 1'b0;
							end
						end
						OP_VISIT: begin
							if (req.position >= count_q) begin
								res_stat = ST_RANGE;
							end else begin
								res_rd = rd_data;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						default: begin
							count_d = count_q;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.kind = CELL_ROTATE;
				if (scan_last) begin
					load_out = 1'b1;
					if (scan_erase_q) begin
						count_d = keep ? n_q : n_q - POS_W'(1);
					end else if (found_q) begin
						res_found = 1'b1;
						res_fpos  = fpos_q;
					end else if (head_hit) begin
						res_found = 1'b1;
						res_fpos  = step_q[FPOS_W-1:0];
					end
				end
			end
			default: begin
				cmd.kind = CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && scan_start) begin
			scan_erase_q <= (op_e'(req.op) == OP_ERASE);
			key_q        <= (op_e'(req.op) == OP_ERASE) ? rd_data : req.value;
			step_q       <= '0;
			steps_q      <= count_q;
			n_q          <= count_q;
			found_q      <= 1'b0;
			fpos_q       <= '0;
		end else if (state_q == S_SCAN) begin
			step_q <= step_q + POS_W'(1);
			if (!keep) begin
				n_q <= n_q - POS_W'(1);
			end
			if (!scan_erase_q && head_hit && !found_q) begin
				found_q <= 1'b1;
				fpos_q  <= step_q[FPOS_W-1:0];
			end
		end
		if (load_out) begin
			out_rd_q    <= res_rd;
			out_found_q <= res_found;
			out_fpos_q  <= res_fpos;
			out_count_q <= count_d;
			out_stat_q  <= res_stat;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_value     = out_rd_q;
	assign rsp.found          = out_found_q;
	assign rsp.found_position = out_fpos_q;
	assign rsp.entry_count    = out_count_q;
	assign rsp.status         = out_stat_q;

	`SLE_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid_q && state_q == S_IDLE, "reset not applied")
	`SLE_ASSERT(a_scan_no_accept, state_q == S_SCAN |-> !req.ready, "input taken during a scan")
	`SLE_ASSERT(a_scan_slot_free, state_q == S_SCAN |-> !out_valid_q, "result slot busy in scan")
	`SLE_ASSERT(a_count_bound, count_q <= POS_W'(CAP), "entry count above capacity")
	`SLE_ASSERT(a_scan_len, state_q == S_SCAN |-> n_q <= count_q && step_q < steps_q, "scan overrun")
	`SLE_ASSERT(a_quick_result, accept && !scan_start |=> rsp.valid, "single cycle result missing")

endmodule

/* src/sle_cell.sv */
`timescale 1ns / 1ps

module sle_cell import sle_pkg::*; (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic [POS_W-1:0]         idx,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic signed [DATA_W-1:0] head_data,
	output logic signed [DATA_W-1:0] data_q
);

	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (cmd.kind)
			CELL_INSERT: begin
				if (idx == cmd.pos) begin
					data_d = cmd.value;
				end else if (idx > cmd.pos) begin
					data_d = left_data;
				end
			end
			CELL_REMOVE: begin
				if (idx >= cmd.pos) begin
					data_d = right_data;
				end
			end
			CELL_ROTATE: begin
				// The head entry wraps to the tail unless it is being dropped.
				if (idx < cmd.tail) begin
					data_d = right_data;
				end else if (idx == cmd.tail && cmd.keep) begin
					data_d = head_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

/* src/sle_row.sv */
`timescale 1ns / 1ps

module sle_row import sle_pkg::*; (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic [IDX_W-1:0]         rd_idx,
	output logic signed [DATA_W-1:0] rd_data,
	output logic signed [DATA_W-1:0] head_data
);

	logic signed [DATA_W-1:0] cell_data [CAP];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_in;
		logic signed [DATA_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_left
			assign left_in = cell_data[i-1];
		end

		if (i == CAP - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_right
			assign right_in = cell_data[i+1];
		end

		sle_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (POS_W'(i)),
			.left_data  (left_in),
			.right_data (right_in),
			.head_data  (cell_data[0]),
			.data_q     (cell_data[i])
		);
	end

	assign head_data = cell_data[0];
	assign rd_data   = cell_data[rd_idx];

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import sle_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int QUIET_LIMIT = 3000;
	localparam int PRINT_CAP = 100;
	localparam int PHASE_ITEMS = 460;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     found;
		logic [FPOS_W-1:0]        found_position;
		logic [POS_W-1:0]         entry_count;
		logic [STAT_W-1:0]        status;
	} list_result_t;

	// Shadow copy of the list plus the results still owed by the block.
	class list_mirror;
		logic signed [DATA_W-1:0] cells [CAP];
		int used;
		int errors;
		list_result_t awaited [$];

		function new();
			used = 0;
			errors = 0;
		endfunction

		task report_mismatch(input string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		function void apply_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
				input logic signed [DATA_W-1:0] val);
			list_result_t r;
			logic signed [DATA_W-1:0] key;
			int p;
			int j;
			int keep;
			r = '0;
			p = int'(pos);
			case (op)
			OP_INSERT: begin
				// A full list is rejected before the position is looked at.
				if (used >= CAP) begin
					r.status = ST_FULL;
				end else if (p > used) begin
					r.status = ST_RANGE;
				end else begin
					for (j = used; j > p; j--)
						cells[j] = cells[j-1];
					cells[p] = val;
					used++;
				end
			end
			OP_REMOVE: begin
				if (p >= used) begin
					r.status = ST_RANGE;
				end else begin
					for (j = p; j + 1 < used; j++)
						cells[j] = cells[j+1];
					used--;
				end
			end
			OP_ERASE: begin
				if (p >= used) begin
					r.status = ST_RANGE;
				end else begin
					key = cells[p];
					keep = 0;
					for (j = 0; j < used; j++) begin
						if (cells[j] != key) begin
							cells[keep] = cells[j];
							keep++;
						end
					end
					used = keep;
				end
			end
			OP_SEARCH: begin
				for (j = 0; j < used && !r.found; j++) begin
					if (cells[j] == val) begin
						r.found = 1'b1;
						r.found_position = FPOS_W'(j);
					end
				end
			end
			OP_VISIT: begin
				if (p >= used)
					r.status = ST_RANGE;
				else
					r.read_value = cells[p];
			end
			OP_CLEAR: begin
				used = 0;
			end
			default: begin
			end
			endcase
			r.entry_count = POS_W'(used);
			awaited.push_back(r);
		endfunction

		task check_result(input list_result_t got);
			list_result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("result arrived with nothing outstanding");
				return;
			end
			want = awaited.pop_front();
			if (got.read_value !== want.read_value)
				report_mismatch($sformatf("read_value %0d, wanted %0d",
					got.read_value, want.read_value));
			if (got.found !== want.found)
				report_mismatch($sformatf("found %b, wanted %b", got.found, want.found));
			if (got.found_position !== want.found_position)
				report_mismatch($sformatf("found_position %0d, wanted %0d",
					got.found_position, want.found_position));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count %0d, wanted %0d",
					got.entry_count, want.entry_count));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	bit growing;
	list_mirror sb = new();

	sle_req_if req_ch();
	sle_rsp_if rsp_ch();

	sequential_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result('{read_value: rsp_ch.read_value, found: rsp_ch.found,
				found_position: rsp_ch.found_position, entry_count: rsp_ch.entry_count,
				status: rsp_ch.status});
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Entered and left at a falling edge.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.position <= pos;
		req_ch.value <= val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.apply_request(op, pos, val);
		@(negedge clk);
	endtask

	// Holds the request channel quiet until every outstanding result is back.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.awaited.size() != 0);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) begin
			case ($urandom_range(7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return 32'sd7;
			6: return 32'sh5555_5555;
			default: return 32'shAAAA_AAAA;
			endcase
		end
		if (roll < 70 && sb.used > 0)
			return sb.cells[$urandom_range(sb.used - 1)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
		if ($urandom_range(9) == 0)
			return POS_W'($urandom_range(63));
		if (op == OP_INSERT)
			return POS_W'($urandom_range(sb.used));
		if (sb.used == 0)
			return '0;
		return POS_W'($urandom_range(sb.used - 1));
	endfunction

	task automatic random_request();
		logic [OP_W-1:0] op;
		int roll;
		if (sb.used == CAP && $urandom_range(3) == 0)
			growing = 1'b0;
		if (sb.used == 0)
			growing = 1'b1;
		roll = $urandom_range(99);
		if (growing) begin
			if (roll < 58) op = OP_INSERT;
			else if (roll < 70) op = OP_SEARCH;
			else if (roll < 82) op = OP_VISIT;
			else if (roll < 90) op = OP_REMOVE;
			else if (roll < 95) op = OP_ERASE;
			else if (roll < 96) op = OP_CLEAR;
			else if (roll < 98) op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
			else op = OP_W'($urandom_range(7));
		end else begin
			if (roll < 12) op = OP_INSERT;
			else if (roll < 30) op = OP_SEARCH;
			else if (roll < 45) op = OP_VISIT;
			else if (roll < 75) op = OP_REMOVE;
			else if (roll < 90) op = OP_ERASE;
			else if (roll < 92) op = OP_CLEAR;
			else if (roll < 95) op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
			else op = OP_W'($urandom_range(7));
		end
		send_request(op, pick_position(op), pick_value());
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_INSERT;
		req_ch.position = '0;
		req_ch.value = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		growing = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed edge cases, starting from an empty list.
		send_request(OP_VISIT, 6'd0, 32'sd0);
		send_request(OP_REMOVE, 6'd0, 32'sd0);
		send_request(OP_ERASE, 6'd0, 32'sd0);
		send_request(OP_SEARCH, 6'd0, 32'sd0);
		send_request(OP_INSERT, 6'd1, 32'sd5);
		send_request(OP_INSERT, 6'd63, 32'sd5);
		send_request(OP_INSERT, 6'd0, VAL_MIN);
		send_request(OP_INSERT, 6'd1, VAL_MAX);
		send_request(OP_INSERT, 6'd1, 32'sd0);
		send_request(OP_INSERT, 6'd0, -32'sd1);
		send_request(OP_INSERT, 6'd4, VAL_MAX);
		send_request(OP_SEARCH, 6'd0, VAL_MAX);
		send_request(OP_SEARCH, 6'd0, 32'sd12345);
		send_request(OP_VISIT, 6'd0, 32'sd0);
		send_request(OP_VISIT, POS_W'(sb.used - 1), 32'sd0);
		send_request(OP_VISIT, POS_W'(sb.used), 32'sd0);
		send_request(OP_ERASE, 6'd3, 32'sd0);
		send_request(OP_REMOVE, 6'd0, 32'sd0);
		send_request(OP_REMOVE, POS_W'(sb.used - 1), 32'sd0);
		send_request(OP_UNUSED_LO, 6'd63, VAL_MIN);
		send_request(OP_UNUSED_HI, 6'd0, VAL_MAX);
		send_request(OP_CLEAR, 6'd0, 32'sd0);
		send_request(OP_VISIT, 6'd0, 32'sd0);
		wait_for_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_request();
				if ($urandom_range(149) == 0)
					wait_for_results();
			end
			wait_for_results();
		end

		recv_stall_pct = 0;
		repeat (CAP + 8) @(negedge clk);
		if (sb.awaited.size() != 0)
			sb.report_mismatch("results still outstanding at end of run");
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/sle_pkg.sv
src/sle_req_if.sv
src/sle_rsp_if.sv
src/sle_cell.sv
src/sle_row.sv
src/sequential_list_engine.sv
dv/tb_top.sv
